>>> rtl/cel_pkg.sv
// Shared types and constants of the compacting entry list.
// Depends on nothing; the top level imports it.
package cel_pkg;

	localparam int DEPTH       = 64;
	localparam int ENTRY_WIDTH = 64;

	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int FUNC_W  = 3;
	localparam int VALUE_W = 64;
	localparam int INDEX_W = 6;
	localparam int LEN_W   = 7;

	localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_GET    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_DELETE = 3'd4;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] read_data;
		logic [LEN_W-1:0]   length;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCAN,
		ST_SHIFT,
		ST_RESULT
	} state_t;

endpackage

>>> rtl/compacting_entry_list_top.sv
// Compacting entry list: the whole block, with its entry memory and sequencer.
// Depends on cel_pkg for the request and response types and the constants.

// The block keeps an ordered list of up to DEPTH entries in one single-port-write,
// single-port-read synchronous memory, and serves one request at a time. A request
// is taken only while the sequencer is idle; the response sits in an output
// register, so the next request can be taken while a response still waits. Push,
// clear and an unknown code go from the execute state straight to the result state,
// pop and get pass through a read state for the memory read. Remove by value scans
// the list one entry per cycle until the first match and then shifts the later
// entries down one per cycle; delete by index shifts the entries above the index.
// Both are bounded by the single memory read port, which moves one entry each
// cycle. Entry contents are not cleared on reset; only positions below the length
// are ever read.
module compacting_entry_list_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cel_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cel_pkg::rsp_t rsp
);
	import cel_pkg::*;

	// Control state.
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             rsp_valid_q;

	// Latched request and work registers.
	logic [FUNC_W-1:0]      op_func_q;
	logic [ENTRY_WIDTH-1:0] op_value_q;
	logic [INDEX_W-1:0]     op_index_q;
	logic [ADDR_W-1:0]      ptr_q, ptr_d;
	logic                   ok_q, ok_d;
	logic [ENTRY_WIDTH-1:0] rd_q, rd_d;
	rsp_t                   rsp_q;

	// Memory and its ports.
	logic [ENTRY_WIDTH-1:0] entry_mem_q [DEPTH];
	logic [ENTRY_WIDTH-1:0] rd_data_s1;
	logic                   mem_we, mem_re;
	logic [ADDR_W-1:0]      mem_wa, mem_ra;
	logic [ENTRY_WIDTH-1:0] mem_wd;

	logic              accept;
	logic              load_out;
	logic              idx_in_range;
	logic [ADDR_W-1:0] shift_from;
	logic              shift_more;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_in_range = (32'(op_index_q) < 32'(cnt_q));

	// A compaction starts either at the matching entry found by the scan or at
	// the requested index. When nothing lies above that position, the entry is
	// dropped by shortening the list alone.
	assign shift_from = (state_q == ST_SCAN) ? ptr_q : ADDR_W'(op_index_q);
	assign shift_more = (CNT_W'(shift_from) + CNT_W'(1)) < cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rsp_valid_q <= load_out || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_func_q  <= req.func;
			op_value_q <= req.value[ENTRY_WIDTH-1:0];
			op_index_q <= req.index;
		end
		ptr_q <= ptr_d;
		ok_q  <= ok_d;
		rd_q  <= rd_d;
		if (load_out) begin
			rsp_q.ok        <= ok_q;
			rsp_q.read_data <= VALUE_W'(rd_q);
			rsp_q.length    <= LEN_W'(cnt_q);
		end
	end

	// Entry memory. During a shift the write goes to the slot just below the
	// entry being read, so the read and write addresses never meet and no
	// forwarding is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_s1 <= entry_mem_q[mem_ra];
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ptr_d    = ptr_q;
		ok_d     = ok_q;
		rd_d     = rd_q;
		mem_we   = 1'b0;
		mem_wa   = ptr_q;
		mem_wd   = rd_data_s1;
		mem_re   = 1'b0;
		mem_ra   = ptr_q;
		load_out = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// Failure is the default; only a successful path raises ok.
				ok_d    = 1'b0;
				rd_d    = '0;
				state_d = ST_RESULT;
				unique case (op_func_q)
					FN_PUSH: begin
						if (cnt_q < CNT_W'(DEPTH)) begin
							mem_we = 1'b1;
							mem_wa = ADDR_W'(cnt_q);
							mem_wd = op_value_q;
							cnt_d  = cnt_q + CNT_W'(1);
							ok_d   = 1'b1;
						end
					end
					FN_POP: begin
						if (cnt_q != '0) begin
							cnt_d   = cnt_q - CNT_W'(1);
							mem_re  = 1'b1;
							mem_ra  = ADDR_W'(cnt_q - CNT_W'(1));
							state_d = ST_READ;
						end
					end
					FN_GET: begin
						if (idx_in_range) begin
							mem_re  = 1'b1;
							mem_ra  = ADDR_W'(op_index_q);
							state_d = ST_READ;
						end
					end
					FN_REMOVE: begin
						if (cnt_q != '0) begin
							mem_re  = 1'b1;
							mem_ra  = '0;
							ptr_d   = '0;
							state_d = ST_SCAN;
						end
					end
					FN_DELETE: begin
						if (idx_in_range) begin
							if (shift_more) begin
								mem_re  = 1'b1;
								mem_ra  = shift_from + ADDR_W'(1);
								ptr_d   = shift_from;
								state_d = ST_SHIFT;
							end else begin
								cnt_d = cnt_q - CNT_W'(1);
								ok_d  = 1'b1;
							end
						end
					end
					FN_CLEAR: begin
						cnt_d = '0;
						ok_d  = 1'b1;
					end
					default: begin
					end
				endcase
			end
			ST_READ: begin
				rd_d    = rd_data_s1;
				ok_d    = 1'b1;
				state_d = ST_RESULT;
			end
			ST_SCAN: begin
				// The word for position ptr_q arrives now; the next read is
				// issued in the same cycle, so the scan moves one entry a cycle.
				if (rd_data_s1 == op_value_q) begin
					if (shift_more) begin
						mem_re  = 1'b1;
						mem_ra  = shift_from + ADDR_W'(1);
						ptr_d   = shift_from;
						state_d = ST_SHIFT;
					end else begin
						cnt_d   = cnt_q - CNT_W'(1);
						ok_d    = 1'b1;
						state_d = ST_RESULT;
					end
				end else if ((CNT_W'(ptr_q) + CNT_W'(1)) < cnt_q) begin
					mem_re = 1'b1;
					mem_ra = ptr_q + ADDR_W'(1);
					ptr_d  = ptr_q + ADDR_W'(1);
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SHIFT: begin
				// The entry above ptr_q has arrived and moves down into ptr_q.
				mem_we = 1'b1;
				mem_wa = ptr_q;
				mem_wd = rd_data_s1;
				if ((CNT_W'(ptr_q) + CNT_W'(2)) < cnt_q) begin
					mem_re = 1'b1;
					mem_ra = ptr_q + ADDR_W'(2);
					ptr_d  = ptr_q + ADDR_W'(1);
				end else begin
					cnt_d   = cnt_q - CNT_W'(1);
					ok_d    = 1'b1;
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("list length exceeds its capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("request transfer did not start execution");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_EXEC && op_func_q == FN_CLEAR) |=>
		(cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CNT_W'(1) ||
		 cnt_q + CNT_W'(1) == $past(cnt_q)))
		else $error("length changed by more than one entry");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.ok) |-> (rsp_q.read_data == '0))
		else $error("failed response carries read data");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> ((CNT_W'(ptr_q) + CNT_W'(1)) < cnt_q))
		else $error("compaction pointer ran past the list end");
`endif

endmodule
